/* rtl/rlel_pkg.sv */
// Shared types and constants of the rate limited event log ring.
`timescale 1ns / 1ps
`default_nettype none
package rlel_pkg;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_RESET_CAUSE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_FLUSH_INTERVAL = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] FLUSH_INTERVAL_RST = 16'd100;

  // floor(t / 1000) for any 32-bit t equals (t * UPTIME_RECIP) >> UPTIME_SHIFT
  localparam logic [28:0] UPTIME_RECIP = 29'd274877907;
  localparam int unsigned UPTIME_SHIFT = 38;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [7:0]  evt_code;
    logic [7:0]  subsystem;
    logic [7:0]  sys_mode;
    logic [7:0]  fault_bits;
    logic [15:0] read_index;
    logic        in_standby;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        flush_request;
    logic [5:0]  count_now;
    logic [31:0] events_total;
    logic [31:0] entry_time_ms;
    logic [7:0]  entry_error;
    logic [7:0]  entry_subsystem;
    logic [7:0]  entry_sysstate;
    logic [7:0]  entry_faults;
    logic [7:0]  entry_cause;
    logic [22:0] entry_uptime_s;
  } out_item_t;

  // One stored log entry
  typedef struct packed {
    logic [31:0] time_ms;
    logic [7:0]  cause;
    logic [7:0]  faults;
    logic [7:0]  sysstate;
    logic [7:0]  subsystem;
    logic [7:0]  error;
  } entry_t;

  // Stage one result, passed from the control stage to the output stage
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic        flush;
    logic        rd_hit;
    logic [5:0]  count_now;
    logic [31:0] total;
  } s1_t;

endpackage
`default_nettype wire

/* rtl/rlel_store.sv */
// Entry memory of the event log: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rlel_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire [AW-1:0]         waddr_i,
  input  wire rlel_pkg::entry_t wdata_i,
  input  wire                  re_i,
  input  wire [AW-1:0]         raddr_i,
  output rlel_pkg::entry_t     rdata_o
);
  import rlel_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/rlel_ctrl.sv */
// Control stage: configuration, ring pointers, counters, flush timing.
`timescale 1ns / 1ps
`default_nettype none
module rlel_ctrl #(
  parameter int unsigned LOG_DEPTH = 32,
  parameter int unsigned AW        = 5
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire [rlel_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire [rlel_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  wire                                    accept_i,
  input  wire                                    take_i,
  input  wire rlel_pkg::in_item_t                item_i,
  output logic                                   mem_we_o,
  output logic [AW-1:0]                          mem_waddr_o,
  output rlel_pkg::entry_t                       mem_wdata_o,
  output logic                                   mem_re_o,
  output logic [AW-1:0]                          mem_raddr_o,
  output rlel_pkg::s1_t                          s1_o
);
  import rlel_pkg::*;

  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

  logic [7:0]    cause_q;
  logic [15:0]   interval_q;
  logic [AW-1:0] wr_pos_q, wr_pos_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   total_q, total_d;
  logic [31:0]   last_q, last_d;
  logic          flushed_q, flushed_d;
  s1_t           s1_q, s1_d;

  logic          full;
  logic          rd_hit;
  logic [AW:0]   rd_sum;
  logic [AW-1:0] rd_pos;
  logic [31:0]   elapsed;
  logic          due;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cause_q    <= '0;
      interval_q <= FLUSH_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REG_RESET_CAUSE:    cause_q    <= cfg_wdata_i[7:0];
        CFG_REG_FLUSH_INTERVAL: interval_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign full    = (count_q == CW'(LOG_DEPTH));
  assign rd_hit  = (32'(item_i.read_index) < 32'(count_q));
  assign rd_sum  = {1'b0, wr_pos_q} + {1'b0, item_i.read_index[AW-1:0]};
  assign elapsed = item_i.now_ms - last_q;
  assign due     = !flushed_q || (elapsed >= {16'b0, interval_q});

  // Oldest entry sits at the write position once the ring has wrapped
  always_comb begin
    if (!full) begin
      rd_pos = item_i.read_index[AW-1:0];
    end else if (rd_sum >= (AW + 1)'(LOG_DEPTH)) begin
      rd_pos = AW'(rd_sum - (AW + 1)'(LOG_DEPTH));
    end else begin
      rd_pos = rd_sum[AW-1:0];
    end
  end

  always_comb begin
    wr_pos_d  = wr_pos_q;
    count_d   = count_q;
    total_d   = total_q;
    last_d    = last_q;
    flushed_d = flushed_q;
    s1_d      = s1_q;
    if (accept_i) begin
      s1_d.valid  = 1'b1;
      s1_d.ok     = 1'b0;
      s1_d.flush  = 1'b0;
      s1_d.rd_hit = 1'b0;
      case (item_i.func)
        FUNC_RECORD: begin
          wr_pos_d = (wr_pos_q == AW'(LOG_DEPTH - 1)) ? '0 : wr_pos_q + 1'b1;
          if (!full) begin
            count_d = count_q + 1'b1;
          end
          if (total_q != '1) begin
            total_d = total_q + 1'b1;
          end
          if (due) begin
            s1_d.flush = 1'b1;
            last_d     = item_i.now_ms;
            flushed_d  = 1'b1;
          end
          s1_d.ok = 1'b1;
        end
        FUNC_READ: begin
          s1_d.ok     = rd_hit;
          s1_d.rd_hit = rd_hit;
        end
        FUNC_CLEAR: begin
          if (item_i.in_standby) begin
            wr_pos_d   = '0;
            count_d    = '0;
            last_d     = item_i.now_ms;
            flushed_d  = 1'b1;
            s1_d.flush = 1'b1;
            s1_d.ok    = 1'b1;
          end
        end
        default: ;
      endcase
      s1_d.count_now = 6'(count_d);
      s1_d.total     = total_d;
    end else if (take_i) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q  <= '0;
      count_q   <= '0;
      total_q   <= '0;
      last_q    <= '0;
      flushed_q <= 1'b0;
      s1_q      <= '0;
    end else begin
      wr_pos_q  <= wr_pos_d;
      count_q   <= count_d;
      total_q   <= total_d;
      last_q    <= last_d;
      flushed_q <= flushed_d;
      s1_q      <= s1_d;
    end
  end

  assign mem_we_o    = accept_i && (item_i.func == FUNC_RECORD);
  assign mem_waddr_o = wr_pos_q;
  assign mem_wdata_o = '{time_ms:   item_i.now_ms,
                         cause:     cause_q,
                         faults:    item_i.fault_bits,
                         sysstate:  item_i.sys_mode,
                         subsystem: item_i.subsystem,
                         error:     item_i.evt_code};
  assign mem_re_o    = accept_i && (item_i.func == FUNC_READ);
  assign mem_raddr_o = rd_pos;
  assign s1_o        = s1_q;

endmodule
`default_nettype wire

/* rtl/rlel_fmt.sv */
// Output stage: entry masking, uptime in seconds, result register.
`timescale 1ns / 1ps
`default_nettype none
module rlel_fmt (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire rlel_pkg::s1_t       s1_i,
  input  wire rlel_pkg::entry_t    rdata_i,
  input  wire                      out_stall_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  output rlel_pkg::out_item_t      out_item_o
);
  import rlel_pkg::*;

  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic [60:0] prod;
  entry_t      ent;

  assign take_o = s1_i.valid && (!out_valid_q || !out_stall_i);
  assign ent    = s1_i.rd_hit ? rdata_i : '0;
  assign prod   = 61'(ent.time_ms) * 61'(UPTIME_RECIP);

  always_comb begin
    out_item_d.ok              = s1_i.ok;
    out_item_d.flush_request   = s1_i.flush;
    out_item_d.count_now       = s1_i.count_now;
    out_item_d.events_total    = s1_i.total;
    out_item_d.entry_time_ms   = ent.time_ms;
    out_item_d.entry_error     = ent.error;
    out_item_d.entry_subsystem = ent.subsystem;
    out_item_d.entry_sysstate  = ent.sysstate;
    out_item_d.entry_faults    = ent.faults;
    out_item_d.entry_cause     = ent.cause;
    out_item_d.entry_uptime_s  = prod[UPTIME_SHIFT +: 23];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

/* rtl/rate_limited_event_log_ring.sv */
// Top level of the rate limited event log ring.
`timescale 1ns / 1ps
`default_nettype none
// Fault event log ring with a rate-limited flush request.
// Input channel: in_valid_i / in_stall_o / in_item_i; one transfer is one
//   operation (record, read by age with 0 the oldest, or clear in standby).
// Output channel: out_valid_o / out_stall_i / out_item_o; each input transfer
//   yields exactly one result transfer, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 reset cause, 1 flush interval in ms); write only while idle.
// Pipeline: two register stages, the stage one register and then the result
//   register; a result is valid once it has passed through both.
// Throughput: one item per cycle unless the output stalls; the memory has one
//   write and one read port and every operation touches at most one of them.
// Stalls: the result register holds while out_stall_i is high; the stage
//   behind it still takes one more item, then in_stall_o rises until the
//   output side drains.
// Reset: pointers, count, lifetime total and flush history clear, the
//   reset cause reads 0 and the flush interval 100 ms. Entry memory is not
//   cleared; only entries below the count ever reach the output.
module rate_limited_event_log_ring #(
  parameter int unsigned LOG_DEPTH = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire rlel_pkg::in_item_t          in_item_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output rlel_pkg::out_item_t              out_item_o,
  input  wire                              cfg_we_i,
  input  wire [rlel_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [rlel_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import rlel_pkg::*;

  localparam int unsigned AW = $clog2(LOG_DEPTH);

  logic          accept;
  logic          take;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  s1_t           s1;

  // Stall only while stage one is full and cannot move on
  assign in_stall_o = s1.valid && !take;
  assign accept     = in_valid_i && !in_stall_o;

  rlel_ctrl #(
    .LOG_DEPTH(LOG_DEPTH),
    .AW       (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .take_i     (take),
    .item_i     (in_item_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .s1_o       (s1)
  );

  rlel_store #(
    .DEPTH(LOG_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  rlel_fmt u_fmt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_i       (s1),
    .rdata_i    (mem_rdata),
    .out_stall_i(out_stall_i),
    .take_o     (take),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

`ifndef SYNTH
  // Input side backs up only when both stages hold an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1.valid && out_valid_o && out_stall_i))
    else $error("input stalled with a free pipeline slot");

  // A failed result carries no entry time, uptime or cause
  a_entry_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.ok) |->
      (out_item_o.entry_time_ms == '0 && out_item_o.entry_uptime_s == '0 &&
       out_item_o.entry_cause == '0))
    else $error("entry fields not cleared on a failed operation");

  // A flush is only requested by a successful record or clear
  a_flush_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.flush_request) |-> out_item_o.ok)
    else $error("flush request on a failed operation");

  // Seconds lie between t/1024 and t/1000
  a_uptime_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_item_o.entry_uptime_s >= out_item_o.entry_time_ms[31:10] &&
       32'(out_item_o.entry_uptime_s) * 32'd1000 <= out_item_o.entry_time_ms))
    else $error("uptime seconds inconsistent with entry time");
`endif

endmodule
`default_nettype wire

/* tb/sv/rate_limited_event_log_ring_tb.sv */
// Self-checking testbench for the rate limited event log ring.
`timescale 1ns / 1ps
module rate_limited_event_log_ring_tb;
  import rlel_pkg::*;

  // The package names three operations; the fourth code must be ignored.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned HOLDOFF_AT = 400;
  localparam int unsigned HOLDOFF_CYCLES = 80;

  typedef struct {
    in_item_t  item;
    bit        pin;
    out_item_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rate_limited_event_log_ring uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the log: ring contents, pointers, flush history, registers.
  // ---------------------------------------------------------------------------
  entry_t      ring [RING_DEPTH];
  logic [4:0]  wr_slot = '0;
  logic [5:0]  fill = '0;
  logic [31:0] lifetime = '0;
  logic [31:0] last_flush = '0;
  logic        flushed = 1'b0;
  logic [7:0]  cur_cause = '0;
  logic [15:0] cur_interval = FLUSH_INTERVAL_RST;

  // Responses still owed by the block, oldest first.
  out_item_t pending_responses [$];

  // Directed rows may pin their response; the driver sets these with the item.
  bit        pin_on = 1'b0;
  out_item_t pin_resp = '0;

  int err_count = 0;
  int n_transfers = 0;
  int n_checked = 0;
  int n_records = 0;
  int n_read_hits = 0;
  int n_clears = 0;
  int n_flushes = 0;
  int n_wrapped_reads = 0;
  int stall_cycles = 0;
  logic [31:0] tick = '0;

  // Apply one operation to the shadow log and return the response it owes.
  function automatic out_item_t log_op_result(in_item_t it);
    out_item_t r;
    entry_t e;
    logic [4:0] slot;
    logic [31:0] elapsed;
    logic [31:0] secs;
    r = '0;
    case (it.func)
      FUNC_RECORD: begin
        e.time_ms   = it.now_ms;
        e.cause     = cur_cause;
        e.faults    = it.fault_bits;
        e.sysstate  = it.sys_mode;
        e.subsystem = it.subsystem;
        e.error     = it.evt_code;
        ring[wr_slot] = e;
        wr_slot = wr_slot + 5'd1;
        if (fill < RING_DEPTH) fill = fill + 6'd1;
        if (lifetime != 32'hFFFF_FFFF) lifetime = lifetime + 32'd1;
        // Modular elapsed time, so a wrap of the tick still counts forward.
        elapsed = it.now_ms - last_flush;
        if (!flushed || elapsed >= {16'd0, cur_interval}) begin
          r.flush_request = 1'b1;
          last_flush = it.now_ms;
          flushed = 1'b1;
        end
        r.ok = 1'b1;
      end
      FUNC_READ: begin
        if (it.read_index < {10'd0, fill}) begin
          // Once full, the oldest entry sits at the write slot.
          slot = (fill == RING_DEPTH) ? wr_slot + it.read_index[4:0] : it.read_index[4:0];
          e = ring[slot];
          secs = e.time_ms / 32'd1000;
          r.ok              = 1'b1;
          r.entry_time_ms   = e.time_ms;
          r.entry_error     = e.error;
          r.entry_subsystem = e.subsystem;
          r.entry_sysstate  = e.sysstate;
          r.entry_faults    = e.faults;
          r.entry_cause     = e.cause;
          r.entry_uptime_s  = secs[22:0];
        end
      end
      FUNC_CLEAR: begin
        if (it.in_standby) begin
          wr_slot = '0;
          fill = '0;
          last_flush = it.now_ms;
          flushed = 1'b1;
          r.flush_request = 1'b1;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count_now = fill;
    r.events_total = lifetime;
    return r;
  endfunction

  function automatic string fmt(out_item_t r);
    return $sformatf("ok=%0d fl=%0d cnt=%0d tot=%0d t=%h e=%h s=%h st=%h f=%h c=%h up=%0d",
                     r.ok, r.flush_request, r.count_now, r.events_total, r.entry_time_ms,
                     r.entry_error, r.entry_subsystem, r.entry_sysstate, r.entry_faults,
                     r.entry_cause, r.entry_uptime_s);
  endfunction

  task automatic log_failure(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // Compare a result transfer with the oldest owed response, field by field.
  task automatic check_response(out_item_t got);
    out_item_t want;
    int bad;
    if (pending_responses.size() == 0) begin
      log_failure($sformatf("[%0t] result with nothing owed: %s", $realtime, fmt(got)));
    end else begin
      want = pending_responses.pop_front();
      bad = 0;
      if (got.ok !== want.ok) bad++;
      if (got.flush_request !== want.flush_request) bad++;
      if (got.count_now !== want.count_now) bad++;
      if (got.events_total !== want.events_total) bad++;
      if (got.entry_time_ms !== want.entry_time_ms) bad++;
      if (got.entry_error !== want.entry_error) bad++;
      if (got.entry_subsystem !== want.entry_subsystem) bad++;
      if (got.entry_sysstate !== want.entry_sysstate) bad++;
      if (got.entry_faults !== want.entry_faults) bad++;
      if (got.entry_cause !== want.entry_cause) bad++;
      if (got.entry_uptime_s !== want.entry_uptime_s) bad++;
      if (bad != 0)
        log_failure($sformatf("[%0t] mismatch in %0d field(s)\n  exp %s\n  got %s",
                              $realtime, bad, fmt(want), fmt(got)));
      n_checked++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's own
  // registers update, so both sides see the same pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Register writes land at the same edge in the shadow copy.
      if (cfg_we) begin
        if (cfg_idx == CFG_REG_RESET_CAUSE) cur_cause = cfg_wdata[7:0];
        else if (cfg_idx == CFG_REG_FLUSH_INTERVAL) cur_interval = cfg_wdata;
      end
      if (in_valid && in_stall) stall_cycles++;
      if (in_valid && !in_stall) begin : accept_input
        out_item_t r;
        if (in_item.func == FUNC_READ && fill == RING_DEPTH &&
            in_item.read_index < RING_DEPTH) n_wrapped_reads++;
        r = log_op_result(in_item);
        if (in_item.func == FUNC_RECORD) n_records++;
        if (in_item.func == FUNC_READ && r.ok) n_read_hits++;
        if (in_item.func == FUNC_CLEAR && r.ok) n_clears++;
        if (r.flush_request) n_flushes++;
        // A pinned row overrides the shadow result; the shadow still advances.
        pending_responses.push_back(pin_on ? pin_resp : r);
        n_transfers++;
      end
      if (out_valid && !out_stall) check_response(out_item);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern whose mode is picked again at random,
  // plus one long hold-off so the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int rx_mode;
    int mode_left;
    int rx_cyc;
    bit hold_done;
    rx_mode = 0;
    mode_left = 0;
    rx_cyc = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cyc++;
      if (!hold_done && n_transfers >= HOLDOFF_AT) begin
        // Hold off while the sender keeps offering items.
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ((rx_cyc % 5) >= 3);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(in_item_t it, bit pin, out_item_t want);
    pin_on = pin;
    pin_resp = want;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed response has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_item_t mk_item(logic [1:0] f, logic [31:0] now, logic [7:0] err,
                                       logic [7:0] sub, logic [7:0] st, logic [7:0] flt,
                                       logic [15:0] idx, logic stby);
    in_item_t it;
    it.func = f;
    it.now_ms = now;
    it.evt_code = err;
    it.subsystem = sub;
    it.sys_mode = st;
    it.fault_bits = flt;
    it.read_index = idx;
    it.in_standby = stby;
    return it;
  endfunction

  // Response with empty entry fields, as every non-read or rejected read owes.
  function automatic out_item_t plain_resp(logic ok, logic fl, logic [5:0] cnt,
                                           logic [31:0] tot);
    out_item_t r;
    r = '0;
    r.ok = ok;
    r.flush_request = fl;
    r.count_now = cnt;
    r.events_total = tot;
    return r;
  endfunction

  // Random operation; the tick mostly creeps forward so the interval matters.
  function automatic in_item_t random_item(int clear_pct);
    int pick;
    int step;
    logic [1:0] f;
    logic [15:0] idx;
    step = $urandom_range(0, 99);
    if (step < 70) tick = tick + $urandom_range(0, 60);
    else if (step < 90) tick = tick + $urandom_range(60, 300);
    else if (step < 97) tick = tick + $urandom_range(0, 70000);
    else tick = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 52) f = FUNC_RECORD;
    else if (pick < 52 + 38) f = FUNC_READ;
    else if (pick < 90 + clear_pct) f = FUNC_CLEAR;
    else f = FUNC_UNUSED;
    if ($urandom_range(0, 99) < 80) idx = 16'($urandom_range(0, fill + 1));
    else idx = 16'($urandom);
    return mk_item(f, tick, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), idx,
                   1'($urandom_range(0, 1)));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t rows [$];
    stim_row_t row;
    out_item_t rd0;
    int ph;
    int k;
    int burst_left;
    int clear_pct;
    bit gapless;
    int waits;

    // Reset cause 0 and interval 100 hold during the directed table.
    rd0 = plain_resp(1'b1, 1'b0, 6'd3, 32'd3);
    rd0.entry_error = 8'hFF;
    rd0.entry_sysstate = 8'hFF;

    // Empty log: a read, a clear outside standby and the unused code all fail.
    row.pin = 1'b1;
    row.item = mk_item(FUNC_READ, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0);
    row.want = plain_resp(1'b0, 1'b0, 6'd0, 32'd0);
    rows.push_back(row);
    row.item = mk_item(FUNC_CLEAR, 32'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
    rows.push_back(row);
    row.item = mk_item(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    rows.push_back(row);
    // First record always flushes; 99 ms later is too soon, 100 ms is not.
    row.item = mk_item(FUNC_RECORD, 32'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'd0, 1'b0);
    row.want = plain_resp(1'b1, 1'b1, 6'd1, 32'd1);
    rows.push_back(row);
    row.item = mk_item(FUNC_RECORD, 32'd99, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, 1'b1);
    row.want = plain_resp(1'b1, 1'b0, 6'd2, 32'd2);
    rows.push_back(row);
    row.item = mk_item(FUNC_RECORD, 32'd100, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 16'd0, 1'b0);
    row.want = plain_resp(1'b1, 1'b1, 6'd3, 32'd3);
    rows.push_back(row);
    // Oldest entry, then indexes at and far beyond the count.
    row.item = mk_item(FUNC_READ, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b1);
    row.want = rd0;
    rows.push_back(row);
    row.item = mk_item(FUNC_READ, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd3, 1'b0);
    row.want = plain_resp(1'b0, 1'b0, 6'd3, 32'd3);
    rows.push_back(row);
    row.item = mk_item(FUNC_READ, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0);
    rows.push_back(row);
    // Tick at its top, then wrapped around: the elapsed time is modular.
    row.pin = 1'b0;
    row.item = mk_item(FUNC_RECORD, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'd0, 1'b0);
    rows.push_back(row);
    row.item = mk_item(FUNC_RECORD, 32'd5, 8'h01, 8'h02, 8'h04, 8'h08, 16'd0, 1'b0);
    rows.push_back(row);
    row.item = mk_item(FUNC_READ, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd3, 1'b0);
    rows.push_back(row);
    row.item = mk_item(FUNC_READ, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd4, 1'b0);
    rows.push_back(row);
    // Clear in standby keeps the total and restarts the interval.
    row.pin = 1'b1;
    row.item = mk_item(FUNC_CLEAR, 32'd1000, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b1);
    row.want = plain_resp(1'b1, 1'b1, 6'd0, 32'd5);
    rows.push_back(row);
    row.item = mk_item(FUNC_READ, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0);
    row.want = plain_resp(1'b0, 1'b0, 6'd0, 32'd5);
    rows.push_back(row);
    row.pin = 1'b0;
    row.item = mk_item(FUNC_RECORD, 32'd1099, 8'h80, 8'h40, 8'h20, 8'h10, 16'd0, 1'b0);
    rows.push_back(row);
    row.item = mk_item(FUNC_RECORD, 32'd1100, 8'h7F, 8'hBF, 8'hDF, 8'hEF, 16'd0, 1'b1);
    rows.push_back(row);
    row.pin = 1'b1;
    row.item = mk_item(FUNC_CLEAR, 32'd2000, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0);
    row.want = plain_resp(1'b0, 1'b0, 6'd2, 32'd7);
    rows.push_back(row);

    // Hold reset, then release it at a falling edge.
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_item(rows[i].item, rows[i].pin, rows[i].want);

    // Random phases, each under its own register setting.
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      gapless = 1'b0;
      clear_pct = 1;
      case (ph)
        0: begin
          // Interval zero: every record flushes; widest cause.
          write_reg(CFG_REG_RESET_CAUSE, {8'($urandom_range(0, 255)), 8'hFF});
          write_reg(CFG_REG_FLUSH_INTERVAL, 16'd0);
        end
        1: begin
          write_reg(CFG_REG_RESET_CAUSE, 16'($urandom));
          write_reg(CFG_REG_FLUSH_INTERVAL, 16'hFFFF);
          tick = 32'hFFFF_F000;
        end
        2: begin
          write_reg(CFG_REG_RESET_CAUSE, 16'd0);
          write_reg(CFG_REG_FLUSH_INTERVAL, 16'd1);
          clear_pct = 5;
        end
        3: begin
          write_reg(CFG_REG_RESET_CAUSE, 16'($urandom));
          write_reg(CFG_REG_FLUSH_INTERVAL, FLUSH_INTERVAL_RST);
          gapless = 1'b1;
        end
        default: begin
          write_reg(CFG_REG_RESET_CAUSE, 16'($urandom));
          write_reg(CFG_REG_FLUSH_INTERVAL, 16'($urandom_range(0, 400)));
          clear_pct = 3;
        end
      endcase
      burst_left = 0;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (!gapless) idle_cycles($urandom_range(0, 6));
        end
        burst_left--;
        send_item(random_item(clear_pct), 1'b0, '0);
      end
    end

    // Wind down: wait for every owed response, then idle before the final check.
    in_valid <= 1'b0;
    waits = 0;
    while (pending_responses.size() != 0 && waits < 2000) begin
      @(posedge clk_i);
      waits++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_responses.size() != 0)
      log_failure($sformatf("%0d response(s) never arrived", pending_responses.size()));

    $display("Covered %0d transfers: %0d records, %0d read hits (%0d on a full ring),",
             n_transfers, n_records, n_read_hits, n_wrapped_reads);
    $display("  %0d clears, %0d flush requests, %0d input stall cycles, %0d mismatches",
             n_clears, n_flushes, stall_cycles, err_count);
    if (err_count == 0) begin
      $display("rate_limited_event_log_ring_tb passed");
    end else begin
      $display("rate_limited_event_log_ring_tb failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("rate_limited_event_log_ring_tb failed");
    $finish;
  end

endmodule
